### src/qrps_pkg.sv
// Types, constants and corner helpers for the quad random point sampler.
// No dependencies.
package qrps_pkg;

    localparam int RAND_W  = 16;
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int LEN_W   = 25;
    localparam int RAD_W   = 2 * LEN_W;
    localparam int REM_W   = LEN_W + 2;
    localparam int SUM_W   = LEN_W + 2;
    localparam int PICK_W  = RAND_W + SUM_W;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_CORNER_ONE   = 3'd0,
        REG_CORNER_TWO   = 3'd1,
        REG_CORNER_THREE = 3'd2,
        REG_CORNER_FOUR  = 3'd3,
        REG_EDGE_MODE    = 3'd4
    } qrps_reg_t;

    typedef struct packed {
        logic [3:0][CFG_W-1:0] corner;
        logic                  edge_mode;
    } qrps_cfg_t;

    typedef struct packed {
        logic             busy;
        logic [SUM_W-1:0] run1;
        logic [SUM_W-1:0] run2;
        logic [SUM_W-1:0] run3;
        logic [SUM_W-1:0] total;
    } qrps_sums_t;

    function automatic logic signed [COORD_W-1:0] corner_x(input logic [CFG_W-1:0] c);
        corner_x = $signed(c[31:16]);
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_y(input logic [CFG_W-1:0] c);
        corner_y = $signed(c[15:0]);
    endfunction

endpackage

### src/qrps_if.sv
// Handshake channel interfaces for sample input and point output.
// Depends on nothing.
interface qrps_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] rand_first;
    logic [15:0] rand_second;
    modport source(output valid, rand_first, rand_second, input ready);
    modport sink(input valid, rand_first, rand_second, output ready);
endinterface

interface qrps_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    modport source(output valid, point_x, point_y, input ready);
    modport sink(input valid, point_x, point_y, output ready);
endinterface

### src/quad_random_point_sampler.sv
// Top level: config registers, side length sequencer and point pipeline.
// Depends on qrps_pkg, qrps_if, qrps_len, qrps_dp.
//
//  port        dir   transfer
//  sample_in   sink  rand_first, rand_second
//  point_out   src   point_x, point_y
//  cfg_*       in    write enable, index, data (no read-back)
//
// One point per cycle through four register stages while point_out is ready and no length update runs.
// A write to a corner recomputes the side lengths through one
// shared bit-serial square root, with sample_in.ready low until done.
// Reset is asynchronous, active low; config registers, lengths and sums read as zero.
// Backpressure on point_out stalls only the stages that are full.
module quad_random_point_sampler (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    qrps_in_if.sink                  sample_in,
    qrps_out_if.source               point_out
);
    import qrps_pkg::*;

    qrps_cfg_t  cfg_reg;
    qrps_sums_t sums;
    logic       start;
    logic       dp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CORNER_ONE:   cfg_reg.corner[0] <= cfg_data;
                REG_CORNER_TWO:   cfg_reg.corner[1] <= cfg_data;
                REG_CORNER_THREE: cfg_reg.corner[2] <= cfg_data;
                REG_CORNER_FOUR:  cfg_reg.corner[3] <= cfg_data;
                REG_EDGE_MODE:    cfg_reg.edge_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign start = cfg_we && (cfg_index inside {REG_CORNER_ONE, REG_CORNER_TWO,
                                                REG_CORNER_THREE, REG_CORNER_FOUR});

    qrps_len u_len (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cfg   (cfg_reg),
        .sums  (sums)
    );

    qrps_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .sums        (sums),
        .in_valid    (sample_in.valid && !sums.busy),
        .in_ready    (dp_ready),
        .rand_first  (sample_in.rand_first),
        .rand_second (sample_in.rand_second),
        .out_valid   (point_out.valid),
        .out_ready   (point_out.ready),
        .point_x     (point_out.point_x),
        .point_y     (point_out.point_y)
    );

    assign sample_in.ready = dp_ready && !sums.busy;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        sums.busy |-> !sample_in.ready)
        else $error("input transfer allowed during length update");

    a_corner_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_CORNER_ONE) |=> sums.busy)
        else $error("corner write did not start length update");

endmodule

### src/qrps_len.sv
// Side length sequencer: squares, bit-serial square root, running sums.
// Depends on qrps_pkg.
module qrps_len (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  qrps_pkg::qrps_cfg_t cfg,
    output qrps_pkg::qrps_sums_t sums
);
    import qrps_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQX  = 5'b00010,
        ST_SQY  = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_SUM  = 5'b10000
    } len_state_t;

    len_state_t state_reg, state_next;
    logic [1:0]       side_reg, side_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [RAD_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0][LEN_W-1:0] len_reg;
    logic [SUM_W-1:0] run1_reg, run2_reg, run3_reg, total_reg;

    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [PROD_W-1:0] dsq;
    logic [SQ_W-1:0]   sq_sum;
    logic [REM_W+1:0]  rem_sh, trial;
    logic [1:0]        side_nx;

    always_comb
    begin
        side_nx = side_reg + 2'd1;
        dx = DIFF_W'(corner_x(cfg.corner[side_nx])) - DIFF_W'(corner_x(cfg.corner[side_reg]));
        dy = DIFF_W'(corner_y(cfg.corner[side_nx])) - DIFF_W'(corner_y(cfg.corner[side_reg]));
        dsq = (state_reg == ST_SQX) ? dx * dx : dy * dy;
        sq_sum = sq_reg + dsq[SQ_W-1:0];
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = (REM_W+2)'({root_reg, 2'b01});
    end

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        sq_next    = sq_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: ;
            ST_SQX:
            begin
                sq_next    = dsq[SQ_W-1:0];
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                rad_next   = {1'b0, sq_sum, 16'b0};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (rem_sh >= trial)
                begin
                    rem_next  = REM_W'(rem_sh - trial);
                    root_next = {root_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(rem_sh);
                    root_next = {root_reg[LEN_W-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(LEN_W - 1))
                begin
                    side_next  = side_nx;
                    state_next = (side_reg == 2'd3) ? ST_SUM : ST_SQX;
                end
            end
            ST_SUM: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (start)
        begin
            state_next = ST_SQX;
            side_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= '0;
            len_reg   <= '0;
            run1_reg  <= '0;
            run2_reg  <= '0;
            run3_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            if (state_reg == ST_ROOT && cnt_reg == CNT_W'(LEN_W - 1))
                len_reg[side_reg] <= root_next;
            if (state_reg == ST_SUM)
            begin
                run1_reg  <= SUM_W'(len_reg[0]);
                run2_reg  <= SUM_W'(len_reg[0]) + SUM_W'(len_reg[1]);
                run3_reg  <= SUM_W'(len_reg[0]) + SUM_W'(len_reg[1]) + SUM_W'(len_reg[2]);
                total_reg <= SUM_W'(len_reg[0]) + SUM_W'(len_reg[1])
                           + SUM_W'(len_reg[2]) + SUM_W'(len_reg[3]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign sums.busy  = (state_reg != ST_IDLE);
    assign sums.run1  = run1_reg;
    assign sums.run2  = run2_reg;
    assign sums.run3  = run3_reg;
    assign sums.total = total_reg;

endmodule

### src/qrps_dp.sv
// Four-stage point pipeline: pick/fold, side select, products, round and saturate.
// Depends on qrps_pkg.
module qrps_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qrps_pkg::qrps_cfg_t  cfg,
    input  qrps_pkg::qrps_sums_t sums,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          rand_first,
    input  logic [15:0]          rand_second,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   point_x,
    output logic signed [15:0]   point_y
);
    import qrps_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1
    logic              mode1_reg, fold1_reg;
    logic [RAND_W-1:0] s1_reg, t1_reg;
    logic [PICK_W-1:0] pick1_reg;
    logic              fold_next;
    logic [RAND_W-1:0] s_next, t_next;

    // stage 2
    logic [RAND_W-1:0]        ca2_reg, cb2_reg;
    logic signed [DIFF_W-1:0] dax2_reg, day2_reg, dbx2_reg, dby2_reg;
    logic signed [COORD_W-1:0] bx2_reg, by2_reg;
    logic [1:0]               sel;
    logic [1:0]               sel_nx, base_idx;
    logic [RAND_W-1:0]        ca_next, cb_next;
    logic signed [DIFF_W-1:0] dax_next, day_next, dbx_next, dby_next;
    logic signed [COORD_W-1:0] bx_next, by_next;

    // stage 3
    logic signed [PROD_W-1:0]  pax3_reg, pay3_reg, pbx3_reg, pby3_reg;
    logic signed [COORD_W-1:0] bx3_reg, by3_reg;

    // stage 4
    logic signed [15:0] px4_reg, py4_reg;
    logic signed [15:0] px_next, py_next;

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // fold applies to surface mode only
    always_comb
    begin
        fold_next = !cfg.edge_mode
                  && (({1'b0, rand_first} + {1'b0, rand_second}) > 17'h10000);
        s_next = fold_next ? RAND_W'(17'h10000 - {1'b0, rand_first}) : rand_first;
        t_next = fold_next ? RAND_W'(17'h10000 - {1'b0, rand_second}) : rand_second;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg <= cfg.edge_mode;
            fold1_reg <= fold_next;
            s1_reg    <= s_next;
            t1_reg    <= t_next;
            pick1_reg <= rand_first * sums.total;
        end
    end

    always_comb
    begin
        if (pick1_reg < {sums.run1, 16'b0})
            sel = 2'd0;
        else if (pick1_reg < {sums.run2, 16'b0})
            sel = 2'd1;
        else if (pick1_reg < {sums.run3, 16'b0})
            sel = 2'd2;
        else
            sel = 2'd3;
        sel_nx   = sel + 2'd1;
        base_idx = fold1_reg ? 2'd2 : 2'd0;
        if (mode1_reg)
        begin
            ca_next  = t1_reg;
            cb_next  = '0;
            bx_next  = corner_x(cfg.corner[sel]);
            by_next  = corner_y(cfg.corner[sel]);
            dax_next = DIFF_W'(corner_x(cfg.corner[sel_nx])) - DIFF_W'(bx_next);
            day_next = DIFF_W'(corner_y(cfg.corner[sel_nx])) - DIFF_W'(by_next);
            dbx_next = '0;
            dby_next = '0;
        end
        else
        begin
            ca_next  = s1_reg;
            cb_next  = t1_reg;
            bx_next  = corner_x(cfg.corner[base_idx]);
            by_next  = corner_y(cfg.corner[base_idx]);
            dax_next = DIFF_W'(corner_x(cfg.corner[1])) - DIFF_W'(bx_next);
            day_next = DIFF_W'(corner_y(cfg.corner[1])) - DIFF_W'(by_next);
            dbx_next = DIFF_W'(corner_x(cfg.corner[3])) - DIFF_W'(bx_next);
            dby_next = DIFF_W'(corner_y(cfg.corner[3])) - DIFF_W'(by_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            ca2_reg  <= ca_next;
            cb2_reg  <= cb_next;
            dax2_reg <= dax_next;
            day2_reg <= day_next;
            dbx2_reg <= dbx_next;
            dby2_reg <= dby_next;
            bx2_reg  <= bx_next;
            by2_reg  <= by_next;
        end
        if (en3)
        begin
            pax3_reg <= $signed({1'b0, ca2_reg}) * dax2_reg;
            pay3_reg <= $signed({1'b0, ca2_reg}) * day2_reg;
            pbx3_reg <= $signed({1'b0, cb2_reg}) * dbx2_reg;
            pby3_reg <= $signed({1'b0, cb2_reg}) * dby2_reg;
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;
        end
        if (en4)
        begin
            px4_reg <= px_next;
            py4_reg <= py_next;
        end
    end

    function automatic logic signed [15:0] round_sat(
        input logic signed [PROD_W-1:0]  a,
        input logic signed [PROD_W-1:0]  b,
        input logic signed [COORD_W-1:0] base
    );
        logic signed [PROD_W:0] acc;
        logic signed [19:0]     r;
        acc = (PROD_W+1)'(a) + (PROD_W+1)'(b) + (PROD_W+1)'(32768);
        r = 20'($signed(acc[PROD_W:16])) + 20'(base);
        if (r > 20'sd32767)
            round_sat = 16'sh7fff;
        else if (r < -20'sd32768)
            round_sat = 16'sh8000;
        else
            round_sat = r[15:0];
    endfunction

    assign px_next = round_sat(pax3_reg, pbx3_reg, bx3_reg);
    assign py_next = round_sat(pay3_reg, pby3_reg, by3_reg);

    assign out_valid = v4_reg;
    assign point_x   = px4_reg;
    assign point_y   = py4_reg;

endmodule
